// ===== hdl/bmc_pkg.sv =====
// shared types, constants and codes for the ball motion and collision step
package bmc_pkg;

	localparam int Q_FRAC   = 16;
	localparam int Q_W      = 32;
	localparam int MUL_A_W  = 42;
	localparam int MUL_B_W  = 25;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int RND_W    = PROD_W - Q_FRAC;
	localparam int SUM_W    = RND_W + 2;
	localparam int GEOM_W   = 34;
	localparam int FRIC_W   = 34;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (Q_FRAC - 1);

	localparam logic [23:0] MASS_GAIN_RST     = 24'd655360;
	localparam logic [15:0] FRICTION_RATE_RST = 16'd6554;
	localparam logic [15:0] BOUNCE_RATE_RST   = 16'd45875;
	localparam logic [31:0] GRAVITY_ACCEL_RST = 32'd642253;
	localparam logic [11:0] FIELD_WIDTH_RST   = 12'd800;
	localparam logic [11:0] FIELD_HEIGHT_RST  = 12'd600;
	localparam logic [9:0]  BALL_EXTENT_RST   = 10'd100;

	typedef enum logic [2:0] {
		OP_SET_FORCE = 3'd0,
		OP_IMPULSE   = 3'd1,
		OP_EDGE      = 3'd2,
		OP_BOX       = 3'd3,
		OP_INTEGRATE = 3'd4
	} op_e;

	typedef enum logic [2:0] {
		REG_MASS_GAIN     = 3'd0,
		REG_FRICTION_RATE = 3'd1,
		REG_BOUNCE_RATE   = 3'd2,
		REG_GRAVITY_ACCEL = 3'd3,
		REG_FIELD_WIDTH   = 3'd4,
		REG_FIELD_HEIGHT  = 3'd5,
		REG_BALL_EXTENT   = 3'd6
	} reg_e;

	typedef enum logic [1:0] {
		EDGE_RIGHT  = 2'd0,
		EDGE_LEFT   = 2'd1,
		EDGE_BOTTOM = 2'd2,
		EDGE_TOP    = 2'd3
	} edge_e;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SIMPLE,
		S_EDGE,
		S_EDGE_BNC,
		S_BOX_A,
		S_BOX_B,
		S_BOX_BNC,
		S_I1,
		S_I2,
		S_I3,
		S_I4,
		S_I5,
		S_I6,
		S_I7,
		S_I8,
		S_I9,
		S_DONE
	} state_e;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_FM,
		MUL_FMDT,
		MUL_GDT,
		MUL_VXDT,
		MUL_VYDT,
		MUL_FRIC,
		MUL_FRDT,
		MUL_BX,
		MUL_BY
	} mul_sel_e;

	typedef enum logic [3:0] {
		WB_NONE,
		WB_FM,
		WB_FRIC,
		WB_VX_ADD,
		WB_VX_SUB,
		WB_VY_ADD,
		WB_VY_IMP,
		WB_BX_ADD,
		WB_BY_ADD,
		WB_VX_BOUNCE,
		WB_VY_BOUNCE
	} wb_sel_e;

	typedef enum logic [3:0] {
		POS_NONE,
		POS_ER,
		POS_EL,
		POS_EB,
		POS_ET,
		POS_BOX_R,
		POS_BOX_L,
		POS_BOX_B,
		POS_BOX_T
	} pos_sel_e;

	typedef struct packed {
		logic [23:0] mass_gain;
		logic [15:0] friction_rate;
		logic [15:0] bounce_rate;
		logic [31:0] gravity_accel;
		logic [11:0] field_width;
		logic [11:0] field_height;
		logic [9:0]  ball_extent;
	} cfg_t;

	typedef struct packed {
		logic     in_ready;
		logic     load;
		logic     force_load;
		mul_sel_e mul_sel;
		wb_sel_e  wb_sel;
		pos_sel_e pos_sel;
		logic     set_hit;
		logic     box_capture;
		logic     emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic edge_r;
		logic edge_l;
		logic edge_b;
		logic edge_t;
		logic box_ovl;
		logic box_horiz;
		logic box_pick_r;
		logic box_pick_b;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hdl/bmc_if.sv =====
// item and result channel interfaces
interface bmc_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic signed [31:0] amount;
	logic [15:0]        step_time;
	logic [11:0]        box_left;
	logic [11:0]        box_top;
	logic [11:0]        box_width;
	logic [11:0]        box_height;

	modport source (output valid, operation, amount, step_time, box_left, box_top,
		box_width, box_height, input ready);
	modport sink (input valid, operation, amount, step_time, box_left, box_top,
		box_width, box_height, output ready);
endinterface

interface bmc_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_vx;
	logic signed [31:0] out_vy;
	logic signed [31:0] out_force;
	logic               hit;

	modport source (output valid, out_x, out_y, out_vx, out_vy, out_force, hit,
		input ready);
	modport sink (input valid, out_x, out_y, out_vx, out_vy, out_force, hit,
		output ready);
endinterface

// ===== hdl/bmc_cfg.sv =====
// configuration register file behind the apb port
module bmc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmc_pkg::PADDR_W-1:0]  paddr,
	input  logic [bmc_pkg::PDATA_W-1:0]  pwdata,
	output logic [bmc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output bmc_pkg::cfg_t                cfg
);
	import bmc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mass_gain     <= MASS_GAIN_RST;
			cfg_q.friction_rate <= FRICTION_RATE_RST;
			cfg_q.bounce_rate   <= BOUNCE_RATE_RST;
			cfg_q.gravity_accel <= GRAVITY_ACCEL_RST;
			cfg_q.field_width   <= FIELD_WIDTH_RST;
			cfg_q.field_height  <= FIELD_HEIGHT_RST;
			cfg_q.ball_extent   <= BALL_EXTENT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MASS_GAIN:     cfg_q.mass_gain     <= pwdata[23:0];
				REG_FRICTION_RATE: cfg_q.friction_rate <= pwdata[15:0];
				REG_BOUNCE_RATE:   cfg_q.bounce_rate   <= pwdata[15:0];
				REG_GRAVITY_ACCEL: cfg_q.gravity_accel <= pwdata[31:0];
				REG_FIELD_WIDTH:   cfg_q.field_width   <= pwdata[11:0];
				REG_FIELD_HEIGHT:  cfg_q.field_height  <= pwdata[11:0];
				REG_BALL_EXTENT:   cfg_q.ball_extent   <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MASS_GAIN:     prdata = {8'd0, cfg_q.mass_gain};
			REG_FRICTION_RATE: prdata = {16'd0, cfg_q.friction_rate};
			REG_BOUNCE_RATE:   prdata = {16'd0, cfg_q.bounce_rate};
			REG_GRAVITY_ACCEL: prdata = cfg_q.gravity_accel;
			REG_FIELD_WIDTH:   prdata = {20'd0, cfg_q.field_width};
			REG_FIELD_HEIGHT:  prdata = {20'd0, cfg_q.field_height};
			REG_BALL_EXTENT:   prdata = {22'd0, cfg_q.ball_extent};
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== hdl/bmc_ctrl.sv =====
// controller state machine sequencing the shared multiplier and writebacks
module bmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2:0]          in_op,
	input  bmc_pkg::dp_status_t st,
	output bmc_pkg::ctrl_cmd_t  cmd
);
	import bmc_pkg::*;

	state_e     state_q, state_d;
	edge_e      edge_idx_q, edge_idx_d;
	logic       axis_q, axis_d;
	logic [2:0] op_q;
	logic       edge_hit;
	logic       edge_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			edge_idx_q <= EDGE_RIGHT;
			axis_q     <= 1'b0;
			op_q       <= OP_SET_FORCE;
		end else begin
			state_q    <= state_d;
			edge_idx_q <= edge_idx_d;
			axis_q     <= axis_d;
			if (cmd.load) begin
				op_q <= in_op;
			end
		end
	end

	always_comb begin
		unique case (edge_idx_q)
			EDGE_RIGHT:  edge_hit = st.edge_r;
			EDGE_LEFT:   edge_hit = st.edge_l;
			EDGE_BOTTOM: edge_hit = st.edge_b;
			EDGE_TOP:    edge_hit = st.edge_t;
			default:     edge_hit = 1'b0;
		endcase
	end

	assign edge_last = (edge_idx_q == EDGE_TOP);

	always_comb begin
		state_d         = state_q;
		edge_idx_d      = edge_idx_q;
		axis_d          = axis_q;
		cmd             = '0;
		cmd.mul_sel     = MUL_NONE;
		cmd.wb_sel      = WB_NONE;
		cmd.pos_sel     = POS_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					edge_idx_d = EDGE_RIGHT;
					priority if (in_op == OP_EDGE) begin
						state_d = S_EDGE;
					end else if (in_op == OP_BOX) begin
						state_d = S_BOX_A;
					end else if (in_op == OP_INTEGRATE) begin
						state_d = S_I1;
					end else begin
						state_d = S_SIMPLE;
					end
				end
			end
			S_SIMPLE: begin
				if (op_q == OP_SET_FORCE) begin
					cmd.force_load = 1'b1;
				end else if (op_q == OP_IMPULSE) begin
					cmd.wb_sel = WB_VY_IMP;
				end
				state_d = S_DONE;
			end
			S_EDGE: begin
				if (edge_hit) begin
					cmd.set_hit = 1'b1;
					unique case (edge_idx_q)
						EDGE_RIGHT:  cmd.pos_sel = POS_ER;
						EDGE_LEFT:   cmd.pos_sel = POS_EL;
						EDGE_BOTTOM: cmd.pos_sel = POS_EB;
						EDGE_TOP:    cmd.pos_sel = POS_ET;
						default:     cmd.pos_sel = POS_NONE;
					endcase
					cmd.mul_sel = edge_idx_q[1] ? MUL_BY : MUL_BX;
					state_d     = S_EDGE_BNC;
				end else if (edge_last) begin
					state_d = S_DONE;
				end else begin
					edge_idx_d = edge_e'(edge_idx_q + 2'd1);
				end
			end
			S_EDGE_BNC: begin
				cmd.wb_sel = edge_idx_q[1] ? WB_VY_BOUNCE : WB_VX_BOUNCE;
				if (edge_last) begin
					state_d = S_DONE;
				end else begin
					edge_idx_d = edge_e'(edge_idx_q + 2'd1);
					state_d    = S_EDGE;
				end
			end
			S_BOX_A: begin
				cmd.box_capture = 1'b1;
				state_d         = S_BOX_B;
			end
			S_BOX_B: begin
				if (st.box_ovl) begin
					cmd.set_hit = 1'b1;
					if (st.box_horiz) begin
						cmd.pos_sel = st.box_pick_r ? POS_BOX_R : POS_BOX_L;
						cmd.mul_sel = MUL_BX;
						axis_d      = 1'b0;
					end else begin
						cmd.pos_sel = st.box_pick_b ? POS_BOX_B : POS_BOX_T;
						cmd.mul_sel = MUL_BY;
						axis_d      = 1'b1;
					end
					state_d = S_BOX_BNC;
				end else begin
					state_d = S_DONE;
				end
			end
			S_BOX_BNC: begin
				cmd.wb_sel = axis_q ? WB_VY_BOUNCE : WB_VX_BOUNCE;
				state_d    = S_DONE;
			end
			S_I1: begin
				cmd.mul_sel = MUL_FM;
				state_d     = S_I2;
			end
			S_I2: begin
				cmd.wb_sel  = WB_FM;
				cmd.mul_sel = MUL_GDT;
				state_d     = S_I3;
			end
			S_I3: begin
				cmd.wb_sel  = WB_VY_ADD;
				cmd.mul_sel = MUL_FMDT;
				state_d     = S_I4;
			end
			S_I4: begin
				cmd.wb_sel  = WB_VX_ADD;
				cmd.mul_sel = MUL_VYDT;
				state_d     = S_I5;
			end
			S_I5: begin
				cmd.wb_sel  = WB_BY_ADD;
				cmd.mul_sel = MUL_VXDT;
				state_d     = S_I6;
			end
			S_I6: begin
				cmd.wb_sel  = WB_BX_ADD;
				cmd.mul_sel = MUL_FRIC;
				state_d     = S_I7;
			end
			S_I7: begin
				cmd.wb_sel = WB_FRIC;
				state_d    = S_I8;
			end
			S_I8: begin
				cmd.mul_sel = MUL_FRDT;
				state_d     = S_I9;
			end
			S_I9: begin
				cmd.wb_sel = WB_VX_SUB;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/bmc_dp.sv =====
// datapath: ball state, shared multiplier, rounding, saturation and geometry
module bmc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  bmc_pkg::cfg_t       cfg,
	input  bmc_pkg::ctrl_cmd_t  cmd,
	output bmc_pkg::dp_status_t st,
	bmc_item_if.sink            item,
	bmc_result_if.source        result
);
	import bmc_pkg::*;

	function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(33'sh0_7FFF_FFFF);
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			return {1'b0, {(Q_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			return v[Q_W-1:0];
		end
	endfunction

	// ball state
	logic signed [Q_W-1:0] ball_x_q, ball_y_q, speed_x_q, speed_y_q, push_force_q;
	logic                  hit_q;

	// latched transaction
	logic signed [Q_W-1:0] amount_q;
	logic [15:0]           dt_q;
	logic [11:0]           box_left_q, box_top_q, box_width_q, box_height_q;

	// multiplier and intermediates
	logic signed [MUL_A_W-1:0] mul_a, fm_q;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q, prod_rh;
	logic signed [RND_W-1:0]   rnd, addend;
	logic signed [FRIC_W-1:0]  fric_q;
	logic signed [Q_W-1:0]     base;
	logic                      do_sub;
	logic signed [SUM_W-1:0]   sum;
	logic signed [Q_W-1:0]     wb_val;

	// geometry
	logic signed [GEOM_W-1:0] bx_g, by_g, ext_g, w_g, h_g;
	logic signed [GEOM_W-1:0] left_g, top_g, right_g, bottom_g;
	logic signed [GEOM_W-1:0] lft_ext_g, top_ext_g, er_g, eb_g;
	logic signed [GEOM_W-1:0] ovl_r_q, ovl_l_q, ovl_b_q, ovl_t_q;
	logic signed [GEOM_W-1:0] min_h, min_v;

	// output register
	logic                  out_valid_q;
	logic signed [Q_W-1:0] out_x_q, out_y_q, out_vx_q, out_vy_q, out_force_q;
	logic                  out_hit_q;

	assign item.ready = cmd.in_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			amount_q     <= item.amount;
			dt_q         <= item.step_time;
			box_left_q   <= item.box_left;
			box_top_q    <= item.box_top;
			box_width_q  <= item.box_width;
			box_height_q <= item.box_height;
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_FM: begin
				mul_a = {{(MUL_A_W-Q_W){push_force_q[Q_W-1]}}, push_force_q};
				mul_b = {1'b0, cfg.mass_gain};
			end
			MUL_FMDT: begin
				mul_a = fm_q;
				mul_b = {9'd0, dt_q};
			end
			MUL_GDT: begin
				mul_a = {{(MUL_A_W-Q_W){cfg.gravity_accel[Q_W-1]}}, cfg.gravity_accel};
				mul_b = {9'd0, dt_q};
			end
			MUL_VXDT: begin
				mul_a = {{(MUL_A_W-Q_W){speed_x_q[Q_W-1]}}, speed_x_q};
				mul_b = {9'd0, dt_q};
			end
			MUL_VYDT: begin
				mul_a = {{(MUL_A_W-Q_W){speed_y_q[Q_W-1]}}, speed_y_q};
				mul_b = {9'd0, dt_q};
			end
			MUL_FRIC: begin
				mul_a = {{(MUL_A_W-Q_W){speed_x_q[Q_W-1]}}, speed_x_q};
				mul_b = {9'd0, cfg.friction_rate};
			end
			MUL_FRDT: begin
				mul_a = {{(MUL_A_W-FRIC_W){fric_q[FRIC_W-1]}}, fric_q};
				mul_b = {9'd0, dt_q};
			end
			MUL_BX: begin
				mul_a = {{(MUL_A_W-Q_W){speed_x_q[Q_W-1]}}, speed_x_q};
				mul_b = {9'd0, cfg.bounce_rate};
			end
			MUL_BY: begin
				mul_a = {{(MUL_A_W-Q_W){speed_y_q[Q_W-1]}}, speed_y_q};
				mul_b = {9'd0, cfg.bounce_rate};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// round to nearest, ties up
	assign prod_rh = prod_q + RND_HALF;
	assign rnd     = prod_rh[PROD_W-1:Q_FRAC];
	assign addend  = (cmd.wb_sel == WB_VY_IMP) ?
		{{(RND_W-Q_W){amount_q[Q_W-1]}}, amount_q} : rnd;

	always_comb begin
		do_sub = 1'b0;
		unique case (cmd.wb_sel)
			WB_VX_ADD:    base = speed_x_q;
			WB_VX_SUB: begin
				base   = speed_x_q;
				do_sub = 1'b1;
			end
			WB_VY_ADD,
			WB_VY_IMP:    base = speed_y_q;
			WB_BX_ADD:    base = ball_x_q;
			WB_BY_ADD:    base = ball_y_q;
			WB_VX_BOUNCE,
			WB_VY_BOUNCE: begin
				base   = '0;
				do_sub = 1'b1;
			end
			default:      base = '0;
		endcase
	end

	assign sum = do_sub ?
		{{(SUM_W-Q_W){base[Q_W-1]}}, base} - {{(SUM_W-RND_W){addend[RND_W-1]}}, addend} :
		{{(SUM_W-Q_W){base[Q_W-1]}}, base} + {{(SUM_W-RND_W){addend[RND_W-1]}}, addend};
	assign wb_val = sat32(sum);

	always_ff @(posedge clk) begin
		if (cmd.wb_sel == WB_FM) begin
			fm_q <= rnd[MUL_A_W-1:0];
		end
		if (cmd.wb_sel == WB_FRIC) begin
			fric_q <= rnd[FRIC_W-1:0];
		end
	end

	assign bx_g      = {{(GEOM_W-Q_W){ball_x_q[Q_W-1]}}, ball_x_q};
	assign by_g      = {{(GEOM_W-Q_W){ball_y_q[Q_W-1]}}, ball_y_q};
	assign ext_g     = {8'd0, cfg.ball_extent, 16'd0};
	assign w_g       = {6'd0, cfg.field_width, 16'd0};
	assign h_g       = {6'd0, cfg.field_height, 16'd0};
	assign left_g    = {6'd0, box_left_q, 16'd0};
	assign top_g     = {6'd0, box_top_q, 16'd0};
	assign right_g   = left_g + {6'd0, box_width_q, 16'd0};
	assign bottom_g  = top_g + {6'd0, box_height_q, 16'd0};
	assign lft_ext_g = left_g - ext_g;
	assign top_ext_g = top_g - ext_g;
	assign er_g      = w_g - ext_g;
	assign eb_g      = h_g - ext_g;

	always_ff @(posedge clk) begin
		if (cmd.box_capture) begin
			ovl_r_q <= right_g - bx_g;
			ovl_l_q <= bx_g + ext_g - left_g;
			ovl_b_q <= bottom_g - by_g;
			ovl_t_q <= by_g + ext_g - top_g;
		end
	end

	assign min_h = (ovl_r_q < ovl_l_q) ? ovl_r_q : ovl_l_q;
	assign min_v = (ovl_b_q < ovl_t_q) ? ovl_b_q : ovl_t_q;

	assign st.edge_r     = (bx_g + ext_g) > w_g;
	assign st.edge_l     = ball_x_q[Q_W-1];
	assign st.edge_b     = (by_g + ext_g) > h_g;
	assign st.edge_t     = ball_y_q[Q_W-1];
	assign st.box_ovl    = (ovl_r_q > 0) && (ovl_l_q > 0) && (ovl_b_q > 0) && (ovl_t_q > 0);
	assign st.box_horiz  = min_h < min_v;
	assign st.box_pick_r = ovl_r_q < ovl_l_q;
	assign st.box_pick_b = ovl_b_q < ovl_t_q;
	assign st.out_free   = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_x_q     <= '0;
			ball_y_q     <= '0;
			speed_x_q    <= '0;
			speed_y_q    <= '0;
			push_force_q <= '0;
			hit_q        <= 1'b0;
		end else begin
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (cmd.set_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.force_load) begin
				push_force_q <= amount_q;
			end
			unique case (cmd.wb_sel)
				WB_VX_ADD,
				WB_VX_SUB,
				WB_VX_BOUNCE: speed_x_q <= wb_val;
				WB_VY_ADD,
				WB_VY_IMP,
				WB_VY_BOUNCE: speed_y_q <= wb_val;
				WB_BX_ADD:    ball_x_q  <= wb_val;
				WB_BY_ADD:    ball_y_q  <= wb_val;
				default: ;
			endcase
			unique case (cmd.pos_sel)
				POS_ER:    ball_x_q <= er_g[Q_W-1:0];
				POS_EL:    ball_x_q <= '0;
				POS_EB:    ball_y_q <= eb_g[Q_W-1:0];
				POS_ET:    ball_y_q <= '0;
				POS_BOX_R: ball_x_q <= right_g[Q_W-1:0];
				POS_BOX_L: ball_x_q <= lft_ext_g[Q_W-1:0];
				POS_BOX_B: ball_y_q <= bottom_g[Q_W-1:0];
				POS_BOX_T: ball_y_q <= top_ext_g[Q_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_x_q     <= ball_x_q;
			out_y_q     <= ball_y_q;
			out_vx_q    <= speed_x_q;
			out_vy_q    <= speed_y_q;
			out_force_q <= push_force_q;
			out_hit_q   <= hit_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_x     = out_x_q;
	assign result.out_y     = out_y_q;
	assign result.out_vx    = out_vx_q;
	assign result.out_vy    = out_vy_q;
	assign result.out_force = out_force_q;
	assign result.hit       = out_hit_q;

endmodule

// ===== hdl/ball_motion_and_collision_step.sv =====
// top level of the ball motion and collision step
// one transaction at a time; set force, impulse and unused codes pass through the simple state;
// box check captures the overlaps, then bounces on a hit; edge check tests each edge in turn and
// adds a bounce step per edge hit; integrate runs seven products in sequence through the one shared
// multiplier; the result register frees the input side while it waits
// arst_n clears ball state and force to zero and loads register defaults
module ball_motion_and_collision_step (
	input  logic                         clk,
	input  logic                         arst_n,
	bmc_item_if.sink                     item,
	bmc_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmc_pkg::PADDR_W-1:0]  paddr,
	input  logic [bmc_pkg::PDATA_W-1:0]  pwdata,
	output logic [bmc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import bmc_pkg::*;

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t st;

	bmc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.operation),
		.st       (st),
		.cmd      (cmd)
	);

	bmc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.st     (st),
		.item   (item),
		.result (result)
	);

endmodule

// ===== hdl/bmc_checker.sv =====
// port-level checker for the ball motion and collision step, with its bind
module bmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] result_x,
	input logic        result_hit
);
	logic [1:0] pend_q;
	logic       item_acc;
	logic       res_acc;

	assign item_acc = item_valid && item_ready;
	assign res_acc  = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, item_acc} - {1'b0, res_acc};
		end
	end

	// one transaction in work at a time
	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> !item_ready)
		else $error("input ready stayed high after a transaction");

	// no result without a transaction behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd0) |-> !result_valid)
		else $error("result shown with no transaction outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many transactions outstanding");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_x)
			&& $stable(result_hit))
		else $error("stalled result changed");

endmodule

bind ball_motion_and_collision_step bmc_checker u_bmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_x     (result.out_x),
	.result_hit   (result.hit)
);

// ===== verif/tb.sv =====
// self-checking testbench for the ball motion and collision step: random traffic, fixed-point model
`timescale 1ns / 100ps

module tb;
	import bmc_pkg::*;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam logic [2:0] REG_SPARE      = 3'd7;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] amount;
		logic [15:0]        dt;
		logic [11:0]        bl;
		logic [11:0]        bt;
		logic [11:0]        bw;
		logic [11:0]        bh;
	} ball_move_t;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] push;
		logic               hit;
	} ball_view_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	bmc_item_if   item_ch ();
	bmc_result_if result_ch ();

	ball_motion_and_collision_step uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the ball state and the register file
	longint m_x = 0;
	longint m_y = 0;
	longint m_vx = 0;
	longint m_vy = 0;
	longint m_push = 0;
	logic [23:0]        k_mass   = MASS_GAIN_RST;
	logic [15:0]        k_fric   = FRICTION_RATE_RST;
	logic [15:0]        k_bounce = BOUNCE_RATE_RST;
	logic signed [31:0] k_grav   = GRAVITY_ACCEL_RST;
	logic [11:0]        k_width  = FIELD_WIDTH_RST;
	logic [11:0]        k_height = FIELD_HEIGHT_RST;
	logic [9:0]         k_extent = BALL_EXTENT_RST;

	ball_move_t moves_to_send[$];
	ball_view_t ball_states_due[$];
	ball_move_t on_wire;

	int moves_queued = 0;
	int moves_taken = 0;
	int hits_seen = 0;
	int setups = 0;
	int errors = 0;
	int src_gap = 0;
	int sink_gap = 0;
	bit src_bursty = 1;
	bit sink_bursty = 1;
	bit calm = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic longint q_round(longint p);
		return (p + 64'sd32768) >>> 16;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v;
	endfunction

	function automatic longint rebound(longint v);
		longint b;
		b = k_bounce;
		return clamp32(-q_round(v * b));
	endfunction

	function automatic void advance_ball(ball_move_t mv);
		ball_view_t res;
		longint ext, w, h, lft, tp, rgt, btm, o_r, o_l, o_b, o_t, min_h, min_v;
		longint mass, fric, grav, fm, dt;
		logic hit;
		hit = 1'b0;
		ext = {k_extent, 16'h0000};
		w = {k_width, 16'h0000};
		h = {k_height, 16'h0000};
		mass = k_mass;
		fric = k_fric;
		grav = k_grav;
		dt = mv.dt;
		case (mv.op)
			OP_SET_FORCE: m_push = mv.amount;
			OP_IMPULSE: m_vy = clamp32(m_vy + mv.amount);
			OP_EDGE: begin
				if (m_x + ext > w) begin
					m_x = clamp32(w - ext);
					m_vx = rebound(m_vx);
					hit = 1'b1;
				end
				if (m_x < 0) begin
					m_x = 0;
					m_vx = rebound(m_vx);
					hit = 1'b1;
				end
				if (m_y + ext > h) begin
					m_y = clamp32(h - ext);
					m_vy = rebound(m_vy);
					hit = 1'b1;
				end
				if (m_y < 0) begin
					m_y = 0;
					m_vy = rebound(m_vy);
					hit = 1'b1;
				end
			end
			OP_BOX: begin
				lft = {mv.bl, 16'h0000};
				tp = {mv.bt, 16'h0000};
				rgt = {mv.bw, 16'h0000};
				rgt = rgt + lft;
				btm = {mv.bh, 16'h0000};
				btm = btm + tp;
				if (m_x + ext > lft && m_x < rgt && m_y + ext > tp && m_y < btm) begin
					hit = 1'b1;
					o_r = rgt - m_x;
					o_l = m_x + ext - lft;
					o_b = btm - m_y;
					o_t = m_y + ext - tp;
					min_h = (o_r < o_l) ? o_r : o_l;
					min_v = (o_b < o_t) ? o_b : o_t;
					// equal overlaps resolve vertically
					if (min_h < min_v) begin
						m_x = clamp32((o_r < o_l) ? rgt : lft - ext);
						m_vx = rebound(m_vx);
					end else begin
						m_y = clamp32((o_b < o_t) ? btm : tp - ext);
						m_vy = rebound(m_vy);
					end
				end
			end
			OP_INTEGRATE: begin
				// force times mass is kept wide
				fm = q_round(m_push * mass);
				m_vx = clamp32(m_vx + q_round(fm * dt));
				m_vy = clamp32(m_vy + q_round(grav * dt));
				m_x = clamp32(m_x + q_round(m_vx * dt));
				m_y = clamp32(m_y + q_round(m_vy * dt));
				m_vx = clamp32(m_vx - q_round(q_round(m_vx * fric) * dt));
			end
			default: ;
		endcase
		res.pos_x = m_x[31:0];
		res.pos_y = m_y[31:0];
		res.vel_x = m_vx[31:0];
		res.vel_y = m_vy[31:0];
		res.push = m_push[31:0];
		res.hit = hit;
		ball_states_due.push_back(res);
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			errors++;
		end
	endfunction

	// item side
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				advance_ball(on_wire);
				moves_taken++;
				if ($urandom_range(0, 59) == 0)
					src_bursty = !src_bursty;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					item_ch.valid <= 1'b0;
				end else if (moves_to_send.size() == 0) begin
					item_ch.valid <= 1'b0;
				end else if (!calm && src_bursty && $urandom_range(0, 5) == 0) begin
					src_gap = $urandom_range(0, 6);
					item_ch.valid <= 1'b0;
				end else begin
					on_wire = moves_to_send.pop_front();
					item_ch.operation <= on_wire.op;
					item_ch.amount <= on_wire.amount;
					item_ch.step_time <= on_wire.dt;
					item_ch.box_left <= on_wire.bl;
					item_ch.box_top <= on_wire.bt;
					item_ch.box_width <= on_wire.bw;
					item_ch.box_height <= on_wire.bh;
					item_ch.valid <= 1'b1;
				end
			end
		end
	end

	// result side
	always @(posedge clk) begin
		ball_view_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (ball_states_due.size() == 0) begin
					$error("result with no transaction outstanding");
					errors++;
				end else begin
					want = ball_states_due.pop_front();
					check_field("out_x", want.pos_x, result_ch.out_x);
					check_field("out_y", want.pos_y, result_ch.out_y);
					check_field("out_vx", want.vel_x, result_ch.out_vx);
					check_field("out_vy", want.vel_y, result_ch.out_vy);
					check_field("out_force", want.push, result_ch.out_force);
					check_field("hit", want.hit, result_ch.hit);
					if (want.hit)
						hits_seen++;
				end
				if ($urandom_range(0, 59) == 0)
					sink_bursty = !sink_bursty;
			end
			if (sink_gap > 0) begin
				sink_gap--;
				result_ch.ready <= 1'b0;
			end else if (!calm && sink_bursty && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(0, 6);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	function automatic void queue_move(logic [2:0] op, logic [31:0] amount, logic [15:0] dt,
		logic [11:0] bl, logic [11:0] bt, logic [11:0] bw, logic [11:0] bh);
		ball_move_t mv;
		mv.op = op;
		mv.amount = amount;
		mv.dt = dt;
		mv.bl = bl;
		mv.bt = bt;
		mv.bw = bw;
		mv.bh = bh;
		moves_to_send.push_back(mv);
		moves_queued++;
	endfunction

	function automatic logic [31:0] around_zero(int unsigned span);
		return 32'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int unsigned cap_pix(int unsigned v);
		return (v > 4095) ? 4095 : v;
	endfunction

	// one frame of play, or a stray transaction
	function automatic void queue_frame();
		int unsigned fw, fh, ext;
		logic [15:0] dt;
		fw = k_width;
		fh = k_height;
		ext = k_extent;
		if ($urandom_range(0, 99) < 15) begin
			queue_move($urandom_range(0, 7), $urandom, $urandom_range(0, 65535),
				$urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095));
			return;
		end
		if ($urandom_range(0, 2) == 0)
			queue_move(OP_SET_FORCE, around_zero(1 << 22), $urandom, $urandom, $urandom,
				$urandom, $urandom);
		if ($urandom_range(0, 3) == 0)
			queue_move(OP_IMPULSE, around_zero(1 << 25), $urandom, $urandom, $urandom,
				$urandom, $urandom);
		dt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4369));
		queue_move(OP_INTEGRATE, $urandom, dt, $urandom, $urandom, $urandom, $urandom);
		queue_move(OP_EDGE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if ($urandom_range(0, 1) == 0)
			queue_move(OP_BOX, $urandom, $urandom, cap_pix($urandom_range(0, fw)),
				cap_pix($urandom_range(0, fh)), cap_pix($urandom_range(0, fw / 2 + ext)),
				cap_pix($urandom_range(0, fh / 2 + ext)));
	endfunction

	task automatic bus_cycle(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] want, got;
		want = '0;
		bus_cycle(idx, 1'b1, val, got);
		case (idx)
			REG_MASS_GAIN: begin
				k_mass = val[23:0];
				want = k_mass;
			end
			REG_FRICTION_RATE: begin
				k_fric = val[15:0];
				want = k_fric;
			end
			REG_BOUNCE_RATE: begin
				k_bounce = val[15:0];
				want = k_bounce;
			end
			REG_GRAVITY_ACCEL: begin
				k_grav = val;
				want = val;
			end
			REG_FIELD_WIDTH: begin
				k_width = val[11:0];
				want = k_width;
			end
			REG_FIELD_HEIGHT: begin
				k_height = val[11:0];
				want = k_height;
			end
			REG_BALL_EXTENT: begin
				k_extent = val[9:0];
				want = k_extent;
			end
			default: ;
		endcase
		bus_cycle(idx, 1'b0, '0, got);
		if (idx != REG_SPARE && got !== want) begin
			$error("prdata expected %0d got %0d", want, got);
			errors++;
		end
	endtask

	task automatic choose_setup(input int ph);
		case (ph)
			1: begin
				load_reg(REG_MASS_GAIN, 32'hFFFF_FFFF);
				load_reg(REG_FRICTION_RATE, 32'hFFFF_FFFF);
				load_reg(REG_BOUNCE_RATE, 32'h0);
				load_reg(REG_GRAVITY_ACCEL, 32'h8000_0000);
				load_reg(REG_FIELD_WIDTH, 32'd1);
				load_reg(REG_FIELD_HEIGHT, 32'd1);
				load_reg(REG_BALL_EXTENT, 32'hFFFF_FFFF);
			end
			2: begin
				load_reg(REG_MASS_GAIN, 32'h0);
				load_reg(REG_FRICTION_RATE, 32'h0);
				load_reg(REG_BOUNCE_RATE, 32'h0000_FFFF);
				load_reg(REG_GRAVITY_ACCEL, 32'h7FFF_FFFF);
				load_reg(REG_FIELD_WIDTH, 32'h0000_0FFF);
				load_reg(REG_FIELD_HEIGHT, 32'h0000_0FFF);
				load_reg(REG_BALL_EXTENT, 32'd1);
				load_reg(REG_SPARE, $urandom);
			end
			3: begin
				// degenerate window and ball
				load_reg(REG_FIELD_WIDTH, 32'h0);
				load_reg(REG_FIELD_HEIGHT, 32'h0);
				load_reg(REG_BALL_EXTENT, 32'h0);
				load_reg(REG_MASS_GAIN, $urandom);
				load_reg(REG_FRICTION_RATE, $urandom);
				load_reg(REG_BOUNCE_RATE, $urandom);
				load_reg(REG_GRAVITY_ACCEL, around_zero(1 << 24));
			end
			4: begin
				load_reg(REG_MASS_GAIN, $urandom);
				load_reg(REG_FRICTION_RATE, $urandom);
				load_reg(REG_BOUNCE_RATE, $urandom);
				load_reg(REG_GRAVITY_ACCEL, around_zero(1 << 22));
				load_reg(REG_FIELD_WIDTH, $urandom_range(100, 4095));
				load_reg(REG_FIELD_HEIGHT, $urandom_range(100, 4095));
				load_reg(REG_BALL_EXTENT, $urandom_range(1, 300));
			end
			5: begin
				load_reg(REG_MASS_GAIN, MASS_GAIN_RST);
				load_reg(REG_FRICTION_RATE, FRICTION_RATE_RST);
				load_reg(REG_BOUNCE_RATE, BOUNCE_RATE_RST);
				load_reg(REG_GRAVITY_ACCEL, GRAVITY_ACCEL_RST);
				load_reg(REG_FIELD_WIDTH, FIELD_WIDTH_RST);
				load_reg(REG_FIELD_HEIGHT, FIELD_HEIGHT_RST);
				load_reg(REG_BALL_EXTENT, BALL_EXTENT_RST);
			end
			default: ;
		endcase
		setups++;
	endtask

	task automatic wait_idle();
		while (moves_taken != moves_queued || ball_states_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_SET_FORCE;
		item_ch.amount = '0;
		item_ch.step_time = '0;
		item_ch.box_left = '0;
		item_ch.box_top = '0;
		item_ch.box_width = '0;
		item_ch.box_height = '0;
		result_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// box contact from rest: tie, left, right and bottom pushes, misses
		queue_move(OP_EDGE, 0, 0, 0, 0, 0, 0);
		queue_move(OP_BOX, 0, 0, 50, 50, 100, 100);
		queue_move(OP_EDGE, 0, 0, 0, 0, 0, 0);
		queue_move(OP_BOX, 0, 0, 60, 50, 100, 100);
		queue_move(OP_EDGE, 0, 0, 0, 0, 0, 0);
		queue_move(OP_BOX, 0, 0, 0, 0, 30, 200);
		queue_move(OP_BOX, 0, 0, 0, 0, 200, 20);
		queue_move(OP_BOX, 0, 0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		queue_move(OP_BOX, 0, 0, 0, 0, 0, 0);
		// saturating force and impulse
		queue_move(OP_SET_FORCE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
		queue_move(OP_SET_FORCE, 32'h8000_0000, 0, 0, 0, 0, 0);
		queue_move(OP_IMPULSE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
		queue_move(OP_IMPULSE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
		queue_move(OP_IMPULSE, 32'h8000_0000, 0, 0, 0, 0, 0);
		queue_move(OP_IMPULSE, 32'h8000_0000, 0, 0, 0, 0, 0);
		queue_move(OP_INTEGRATE, 0, 16'hFFFF, 0, 0, 0, 0);
		queue_move(OP_EDGE, 0, 0, 0, 0, 0, 0);
		queue_move(OP_SET_FORCE, 32'h0064_0000, 0, 0, 0, 0, 0);
		queue_move(OP_INTEGRATE, 0, 16'hFFFF, 0, 0, 0, 0);
		queue_move(OP_INTEGRATE, 0, 16'h0000, 0, 0, 0, 0);
		queue_move(OP_EDGE, 0, 0, 0, 0, 0, 0);
		for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
			queue_move(3'(c), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			calm = (ph == 5);
			choose_setup(ph);
			target = moves_queued + 325;
			while (moves_queued < target)
				queue_frame();
		end
		wait_idle();

		$display("%0d transactions checked under %0d register setups, %0d with a collision",
			moves_taken, setups, hits_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/bmc_pkg.sv
hdl/bmc_if.sv
hdl/bmc_cfg.sv
hdl/bmc_ctrl.sv
hdl/bmc_dp.sv
hdl/ball_motion_and_collision_step.sv
hdl/bmc_checker.sv
verif/tb.sv
